// ===== hdl/tlc_pkg.sv =====
// Shared types, codes and constants for the TTL lookup cache.
package tlc_pkg;

    // Fixed widths of the request and response fields.
    localparam int unsigned TAG_IN_W = 32;
    localparam int unsigned IP_W     = 32;
    localparam int unsigned PORT_W   = 16;
    localparam int unsigned TIME_W   = 32;

    // Defaults for the top level parameters.
    localparam int unsigned ENTRIES_DEFAULT   = 2;
    localparam int unsigned TAG_WIDTH_DEFAULT = 32;

    // Lifetime register value after reset.
    localparam logic [TIME_W-1:0] LIFETIME_RESET = 32'd300000;

    // Request action codes.
    localparam logic ACT_LOOKUP = 1'b0;
    localparam logic ACT_STORE  = 1'b1;

    // Result of the shared compare unit for one entry.
    typedef struct packed {
        logic keys_match;
        logic fresh;
    } tlc_cmp_t;

endpackage

// ===== hdl/tlc_req_if.sv =====
// Request channel: valid/ready handshake with the lookup or store payload.
interface tlc_req_if;
    import tlc_pkg::*;

    logic                valid;
    logic                ready;
    logic                action;
    logic [TAG_IN_W-1:0] service_tag;
    logic [TAG_IN_W-1:0] function_tag;
    logic [IP_W-1:0]     target_ip;
    logic [PORT_W-1:0]   target_port;
    logic [TIME_W-1:0]   time_now;

    modport source (
        output valid, action, service_tag, function_tag, target_ip, target_port, time_now,
        input  ready
    );

    modport sink (
        input  valid, action, service_tag, function_tag, target_ip, target_port, time_now,
        output ready
    );
endinterface

// ===== hdl/tlc_rsp_if.sv =====
// Response channel: valid/ready handshake with the hit flag and address.
interface tlc_rsp_if;
    import tlc_pkg::*;

    logic              valid;
    logic              ready;
    logic              hit;
    logic [IP_W-1:0]   found_ip;
    logic [PORT_W-1:0] found_port;

    modport source (
        output valid, hit, found_ip, found_port,
        input  ready
    );

    modport sink (
        input  valid, hit, found_ip, found_port,
        output ready
    );
endinterface

// ===== hdl/tlc_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
module tlc_ram #(
    parameter int unsigned WIDTH = 8,
    parameter int unsigned DEPTH = 2,
    localparam int unsigned AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             clk,
    input  logic             wr_en,
    input  logic [AW-1:0]    wr_addr,
    input  logic [WIDTH-1:0] wr_data,
    input  logic [AW-1:0]    rd_addr,
    output logic [WIDTH-1:0] rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    // Write port.
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    // Registered read port.
    always_ff @(posedge clk)
    begin
        rd_data_reg <= mem[rd_addr];
    end

    assign rd_data = rd_data_reg;

endmodule

// ===== hdl/tlc_match_unit.sv =====
// Shared compare unit: key match and age check for the entry under scan.
module tlc_match_unit
    import tlc_pkg::*;
#(
    parameter int unsigned TAG_WIDTH = TAG_WIDTH_DEFAULT
) (
    input  logic [TAG_WIDTH-1:0] entry_service,
    input  logic [TAG_WIDTH-1:0] entry_function,
    input  logic [TIME_W-1:0]    entry_stamp,
    input  logic [TAG_WIDTH-1:0] key_service,
    input  logic [TAG_WIDTH-1:0] key_function,
    input  logic [TIME_W-1:0]    time_now,
    input  logic [TIME_W-1:0]    lifetime,
    output tlc_cmp_t             result
);

    logic [TIME_W-1:0] age;

    // The age wraps modulo 2^32, so a plain subtraction is enough.
    assign age = time_now - entry_stamp;

    always_comb
    begin
        result.keys_match = (entry_service == key_service) &&
                            (entry_function == key_function);
        result.fresh      = (age < lifetime);
    end

endmodule

// ===== hdl/ttl_lookup_cache.sv =====
// Top level of the TTL lookup cache: scan sequencer, entry store and response register.
//
// Usage:
//   Requests arrive on the req channel and responses leave on the rsp channel;
//   both use valid/ready, and a transfer happens on a clock edge where both are high.
//   A lookup (action 0) scans the entries in index order and answers with the
//   first fresh entry whose service and function tags match; stale matches are
//   invalidated on the way. A store (action 1) writes the first invalid or
//   matching entry, otherwise the entry under the round-robin pointer.
//   Every request gives exactly one response; a store always answers a miss.
//   Each scanned entry passes through a RAM read state and then a compare state,
//   and at most ENTRIES entries are scanned; after the response is registered the
//   sequencer returns to the idle state before it takes the next request.
//   Requests are taken one at a time; req.ready is high only between requests.
//   The response register lets the next request be taken while a response waits;
//   if the receiver stalls, the scan waits at its next compare step until it drains.
//   Reset clears all valid bits, the replacement pointer and the response valid
//   flag, and loads the lifetime register with 300000 ticks. The user must write
//   the lifetime via cfg_wr_en/cfg_wr_data while no request is in flight; unenforced.
module ttl_lookup_cache
    import tlc_pkg::*;
#(
    parameter int unsigned ENTRIES   = ENTRIES_DEFAULT,
    parameter int unsigned TAG_WIDTH = TAG_WIDTH_DEFAULT
) (
    input  logic              clk,
    input  logic              rst_n,
    tlc_req_if.sink           req,
    tlc_rsp_if.source         rsp,
    input  logic              cfg_wr_en,
    input  logic [TIME_W-1:0] cfg_wr_data
);

    localparam int unsigned AW = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
    localparam int unsigned EW = 2 * TAG_WIDTH + IP_W + PORT_W + TIME_W;
    localparam logic [AW-1:0] LAST_IDX = AW'(ENTRIES - 1);

    // Entry word layout, high to low: service, function, ip, port, stamp.
    localparam int unsigned STAMP_LO = 0;
    localparam int unsigned PORT_LO  = STAMP_LO + TIME_W;
    localparam int unsigned IP_LO    = PORT_LO + PORT_W;
    localparam int unsigned FN_LO    = IP_LO + IP_W;
    localparam int unsigned SVC_LO   = FN_LO + TAG_WIDTH;

    // Sequencer states.
    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_READ = 2'd1;
    localparam logic [1:0] S_EVAL = 2'd2;

    logic [1:0]           state_reg, state_next;
    logic [AW-1:0]        idx_reg, idx_next;
    logic [AW-1:0]        ptr_reg, ptr_next;
    logic [ENTRIES-1:0]   valid_reg, valid_next;
    logic [TIME_W-1:0]    lifetime_reg;

    logic                 action_reg;
    logic [TAG_WIDTH-1:0] svc_reg, svc_next;
    logic [TAG_WIDTH-1:0] fn_reg, fn_next;
    logic [IP_W-1:0]      ip_reg;
    logic [PORT_W-1:0]    port_reg;
    logic [TIME_W-1:0]    now_reg;

    logic                 out_valid_reg, out_valid_next;
    logic                 out_hit_reg, out_hit_next;
    logic [IP_W-1:0]      out_ip_reg, out_ip_next;
    logic [PORT_W-1:0]    out_port_reg, out_port_next;

    logic                 ram_we;
    logic [AW-1:0]        ram_waddr;
    logic [EW-1:0]        ram_wdata;
    logic [EW-1:0]        ram_rdata;

    tlc_cmp_t             cmp;
    logic                 req_fire;
    logic                 out_free;
    logic                 entry_live;
    logic                 is_last;

    assign req.ready = (state_reg == S_IDLE);
    assign req_fire  = req.valid && req.ready;
    assign out_free  = !out_valid_reg || rsp.ready;

    // Tags are cut or zero-extended to the stored tag width.
    always_comb
    begin
        for (int b = 0; b < TAG_WIDTH; b++)
        begin
            svc_next[b] = (b < TAG_IN_W) ? req.service_tag[b % TAG_IN_W] : 1'b0;
            fn_next[b]  = (b < TAG_IN_W) ? req.function_tag[b % TAG_IN_W] : 1'b0;
        end
    end

    // Entry storage.
    tlc_ram #(
        .WIDTH (EW),
        .DEPTH (ENTRIES)
    ) u_entries (
        .clk     (clk),
        .wr_en   (ram_we),
        .wr_addr (ram_waddr),
        .wr_data (ram_wdata),
        .rd_addr (idx_reg),
        .rd_data (ram_rdata)
    );

    // Shared compare unit, applied to one entry per scan step.
    tlc_match_unit #(
        .TAG_WIDTH (TAG_WIDTH)
    ) u_match (
        .entry_service  (ram_rdata[SVC_LO +: TAG_WIDTH]),
        .entry_function (ram_rdata[FN_LO +: TAG_WIDTH]),
        .entry_stamp    (ram_rdata[STAMP_LO +: TIME_W]),
        .key_service    (svc_reg),
        .key_function   (fn_reg),
        .time_now       (now_reg),
        .lifetime       (lifetime_reg),
        .result         (cmp)
    );

    assign entry_live = valid_reg[idx_reg];
    assign is_last    = (idx_reg == LAST_IDX);
    assign ram_wdata  = {svc_reg, fn_reg, ip_reg, port_reg, now_reg};

    // Scan sequencer.
    always_comb
    begin
        state_next     = state_reg;
        idx_next       = idx_reg;
        ptr_next       = ptr_reg;
        valid_next     = valid_reg;
        out_valid_next = out_valid_reg && !rsp.ready;
        out_hit_next   = out_hit_reg;
        out_ip_next    = out_ip_reg;
        out_port_next  = out_port_reg;
        ram_we         = 1'b0;
        ram_waddr      = idx_reg;

        unique case (state_reg)
            S_IDLE:
            begin
                if (req_fire)
                begin
                    idx_next   = '0;
                    state_next = S_READ;
                end
            end
            S_READ:
            begin
                state_next = S_EVAL;
            end
            S_EVAL:
            begin
                if (out_free)
                begin
                    if (action_reg == ACT_LOOKUP)
                    begin
                        if (entry_live && cmp.keys_match && cmp.fresh)
                        begin
                            out_valid_next = 1'b1;
                            out_hit_next   = 1'b1;
                            out_ip_next    = ram_rdata[IP_LO +: IP_W];
                            out_port_next  = ram_rdata[PORT_LO +: PORT_W];
                            state_next     = S_IDLE;
                        end
                        else
                        begin
                            // A stale match is dropped and the scan goes on.
                            if (entry_live && cmp.keys_match)
                            begin
                                valid_next[idx_reg] = 1'b0;
                            end
                            if (is_last)
                            begin
                                out_valid_next = 1'b1;
                                out_hit_next   = 1'b0;
                                out_ip_next    = '0;
                                out_port_next  = '0;
                                state_next     = S_IDLE;
                            end
                            else
                            begin
                                idx_next   = idx_reg + AW'(1);
                                state_next = S_READ;
                            end
                        end
                    end
                    else
                    begin
                        if (!entry_live || cmp.keys_match)
                        begin
                            ram_we              = 1'b1;
                            ram_waddr           = idx_reg;
                            valid_next[idx_reg] = 1'b1;
                            out_valid_next      = 1'b1;
                            out_hit_next        = 1'b0;
                            out_ip_next         = '0;
                            out_port_next       = '0;
                            state_next          = S_IDLE;
                        end
                        else if (is_last)
                        begin
                            // No free or matching entry: replace round-robin.
                            ram_we              = 1'b1;
                            ram_waddr           = ptr_reg;
                            valid_next[ptr_reg] = 1'b1;
                            ptr_next            = (ptr_reg == LAST_IDX) ? '0
                                                                       : ptr_reg + AW'(1);
                            out_valid_next      = 1'b1;
                            out_hit_next        = 1'b0;
                            out_ip_next         = '0;
                            out_port_next       = '0;
                            state_next          = S_IDLE;
                        end
                        else
                        begin
                            idx_next   = idx_reg + AW'(1);
                            state_next = S_READ;
                        end
                    end
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // Control state.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            idx_reg       <= '0;
            ptr_reg       <= '0;
            valid_reg     <= '0;
            out_valid_reg <= 1'b0;
            lifetime_reg  <= LIFETIME_RESET;
        end
        else
        begin
            state_reg     <= state_next;
            idx_reg       <= idx_next;
            ptr_reg       <= ptr_next;
            valid_reg     <= valid_next;
            out_valid_reg <= out_valid_next;
            if (cfg_wr_en)
            begin
                lifetime_reg <= cfg_wr_data;
            end
        end
    end

    // Request capture and response payload.
    always_ff @(posedge clk)
    begin
        if (req_fire)
        begin
            action_reg <= req.action;
            svc_reg    <= svc_next;
            fn_reg     <= fn_next;
            ip_reg     <= req.target_ip;
            port_reg   <= req.target_port;
            now_reg    <= req.time_now;
        end
        out_hit_reg  <= out_hit_next;
        out_ip_reg   <= out_ip_next;
        out_port_reg <= out_port_next;
    end

    assign rsp.valid      = out_valid_reg;
    assign rsp.hit        = out_hit_reg;
    assign rsp.found_ip   = out_ip_reg;
    assign rsp.found_port = out_port_reg;

endmodule
